/* rtl/ray_peak_window_centroid_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef RAY_PEAK_WINDOW_CENTROID_CORE_DEFINES_SVH
`define RAY_PEAK_WINDOW_CENTROID_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RPWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpwc assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RPWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpwc assertion failed");

`endif

/* rtl/rpwc_pkg.sv */
package rpwc_pkg;

    // Fixed widths of the port fields
    localparam int IN_COORD_W = 11;
    localparam int INT_W      = 8;
    localparam int OUT_W      = 19;

    // Threshold after reset
    localparam logic [INT_W-1:0] THR_RESET = 8'd128;

    // Divider operand select
    typedef enum logic {
        t_div_sel_x = 1'b0,
        t_div_sel_y = 1'b1
    } t_div_sel;

endpackage

/* rtl/ray_peak_window_centroid_core.sv */
// Channel   | Valid    | Stall    | Payload
// ----------+----------+----------+----------------------------------------------
// sample in | i_valid  | o_stall  | i_pixel_x, i_pixel_y, i_intensity, i_last_sample
// result    | o_valid  | i_stall  | o_found, o_centroid_x, o_centroid_y
// config    | i_cfg_we | -        | i_cfg_data (intensity threshold)
//
// Samples load at one per cycle while o_stall is low. A last-flagged request starts
// evaluation with o_stall high: setup and peak scan, window scan, sum check, two divides
// when the sum is not zero, and a hand-off that waits while the previous result is still
// stalled. When no peak is taken, the hand-off follows the peak scan.
// Reset is synchronous and active low; the sample memory is not cleared.
// A finished result waits in the output register while i_stall is high; loading goes on.
module ray_peak_window_centroid_core #(
    parameter int MAX_RAY_LEN = 1024,
    parameter int COORD_BITS  = 11,
    parameter int FRAC_BITS   = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rpwc_pkg::IN_COORD_W-1:0]  i_pixel_x,
    input  logic [rpwc_pkg::IN_COORD_W-1:0]  i_pixel_y,
    input  logic [rpwc_pkg::INT_W-1:0]       i_intensity,
    input  logic                             i_last_sample,
    input  logic                             i_cfg_we,
    input  logic [rpwc_pkg::INT_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_found,
    output logic [rpwc_pkg::OUT_W-1:0]       o_centroid_x,
    output logic [rpwc_pkg::OUT_W-1:0]       o_centroid_y
);

    localparam int IW    = rpwc_pkg::INT_W;
    localparam int OW    = rpwc_pkg::OUT_W;
    localparam int AW    = $clog2(MAX_RAY_LEN);
    localparam int CNT_W = $clog2(MAX_RAY_LEN + 1);
    localparam int EW    = 2 * COORD_BITS + IW;
    localparam int PW    = COORD_BITS + IW;
    localparam int SX_W  = PW + CNT_W;
    localparam int SV_W  = IW + CNT_W;
    localparam int DIV_W = SX_W + FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RAY_LEN);

    typedef enum logic [3:0] {
        S_LOAD,
        S_SETUP,
        S_PEAK,
        S_LEFT,
        S_RIGHT,
        S_ACC,
        S_SUMCHK,
        S_DIVX,
        S_DIVY,
        S_DONE
    } t_state;

    // Sample memory
    logic [EW-1:0] r_mem [MAX_RAY_LEN];
    logic [EW-1:0] r_rd;

    // Control and working registers
    t_state           r_state,  n_state;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic [IW-1:0]    r_thr,    n_thr;
    logic [AW-1:0]    r_addr,   n_addr;
    logic [AW-1:0]    r_last,   n_last;
    logic [AW-1:0]    r_at,     n_at;
    logic [AW-1:0]    r_lo,     n_lo;
    logic [AW-1:0]    r_hi,     n_hi;
    logic             r_have,   n_have;
    logic [IW-1:0]    r_peak,   n_peak;
    logic [SX_W-1:0]  r_sx,     n_sx;
    logic [SX_W-1:0]  r_sy,     n_sy;
    logic [SV_W-1:0]  r_sv,     n_sv;
    logic             r_res,    n_res;
    logic [DIV_W-1:0] r_qx,     n_qx;
    logic [DIV_W-1:0] r_qy,     n_qy;
    logic             r_ovalid, n_ovalid;
    logic             r_ofound, n_ofound;
    logic [OW-1:0]    r_ocx,    n_ocx;
    logic [OW-1:0]    r_ocy,    n_ocy;

    logic                  w_accept;
    logic                  w_wr;
    logic [COORD_BITS-1:0] w_rd_x;
    logic [COORD_BITS-1:0] w_rd_y;
    logic [IW-1:0]         w_rd_v;
    logic                  w_pass;
    logic [PW-1:0]         w_px;
    logic [PW-1:0]         w_py;
    logic                  w_to_right;
    logic                  w_to_acc;
    logic                  w_div_start;
    rpwc_pkg::t_div_sel    w_div_sel;
    logic [DIV_W-1:0]      w_div_num;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_div_quot;

    assign w_accept = i_valid & ~o_stall;
    assign w_wr     = w_accept & (r_cnt < CNT_MAX);

    // Split the registered read word
    assign w_rd_x = r_rd[EW-1 -: COORD_BITS];
    assign w_rd_y = r_rd[EW-COORD_BITS-1 -: COORD_BITS];
    assign w_rd_v = r_rd[IW-1:0];

    // Window test: 5*v > 4*peak
    assign w_pass = ({3'b000, w_rd_v} + {1'b0, w_rd_v, 2'b00}) > {1'b0, r_peak, 2'b00};

    assign w_px = w_rd_x * w_rd_v;
    assign w_py = w_rd_y * w_rd_v;

    // Memory write port and registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_cnt[AW-1:0]] <= {COORD_BITS'(i_pixel_x), COORD_BITS'(i_pixel_y), i_intensity};
        end
        r_rd <= r_mem[n_addr];
    end

    // Select divider operand
    assign w_div_num = (w_div_sel == rpwc_pkg::t_div_sel_y) ?
                       (DIV_W'(r_sy) << FRAC_BITS) : (DIV_W'(r_sx) << FRAC_BITS);

    rpwc_div #(
        .N_W (DIV_W),
        .D_W (SV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (r_sv),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_thr       = i_cfg_we ? i_cfg_data : r_thr;
        n_addr      = r_addr;
        n_last      = r_last;
        n_at        = r_at;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_have      = r_have;
        n_peak      = r_peak;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sv        = r_sv;
        n_res       = r_res;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_ovalid    = r_ovalid & i_stall;
        n_ofound    = r_ofound;
        n_ocx       = r_ocx;
        n_ocy       = r_ocy;
        w_to_right  = 1'b0;
        w_to_acc    = 1'b0;
        w_div_start = 1'b0;
        w_div_sel   = rpwc_pkg::t_div_sel_x;

        case (r_state)
            S_LOAD: begin
                // Store the request, or drop it when the memory is full
                if (w_accept) begin
                    if (w_wr) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (i_last_sample) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_last  = AW'(r_cnt - 1'b1);
                n_cnt   = '0;
                n_addr  = '0;
                n_have  = 1'b0;
                n_state = S_PEAK;
            end
            S_PEAK: begin
                // Track the brightest sample, later one wins ties
                if (w_rd_v >= (r_have ? r_peak : r_thr)) begin
                    n_have = 1'b1;
                    n_at   = r_addr;
                    n_peak = w_rd_v;
                end
                if (r_addr == r_last) begin
                    if (!n_have) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else if (n_at == '0) begin
                        n_lo       = '0;
                        w_to_right = 1'b1;
                    end else begin
                        n_addr  = n_at - 1'b1;
                        n_state = S_LEFT;
                    end
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_LEFT: begin
                // Extend left, keeping the first failing neighbor
                n_lo = r_addr;
                if (!w_pass || r_addr == '0) begin
                    w_to_right = 1'b1;
                end else begin
                    n_addr = r_addr - 1'b1;
                end
            end
            S_RIGHT: begin
                // Extend right, keeping the first failing neighbor
                n_hi = r_addr;
                if (!w_pass || r_addr == r_last) begin
                    w_to_acc = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_ACC: begin
                // Accumulate the weighted sums over the window
                n_sx = r_sx + SX_W'(w_px);
                n_sy = r_sy + SX_W'(w_py);
                n_sv = r_sv + SV_W'(w_rd_v);
                if (r_addr == r_hi) begin
                    n_state = S_SUMCHK;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SUMCHK: begin
                if (r_sv == '0) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    w_div_sel   = rpwc_pkg::t_div_sel_x;
                    n_state     = S_DIVX;
                end
            end
            S_DIVX: begin
                if (w_div_done) begin
                    n_qx        = w_div_quot;
                    w_div_start = 1'b1;
                    w_div_sel   = rpwc_pkg::t_div_sel_y;
                    n_state     = S_DIVY;
                end
            end
            S_DIVY: begin
                if (w_div_done) begin
                    n_qy    = w_div_quot;
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_res;
                    n_ocx    = r_res ? OW'(r_qx) : '0;
                    n_ocy    = r_res ? OW'(r_qy) : '0;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // Start the right side scan, or go straight to accumulation
        if (w_to_right) begin
            if (n_at == r_last) begin
                n_hi     = n_at;
                w_to_acc = 1'b1;
            end else begin
                n_addr  = n_at + 1'b1;
                n_state = S_RIGHT;
            end
        end
        if (w_to_acc) begin
            n_addr  = n_lo;
            n_sx    = '0;
            n_sy    = '0;
            n_sv    = '0;
            n_state = S_ACC;
        end
    end

    // State, working and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_thr    <= rpwc_pkg::THR_RESET;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_thr    <= n_thr;
            r_addr   <= n_addr;
            r_last   <= n_last;
            r_at     <= n_at;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_have   <= n_have;
            r_peak   <= n_peak;
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_sv     <= n_sv;
            r_res    <= n_res;
            r_qx     <= n_qx;
            r_qy     <= n_qy;
            r_ovalid <= n_ovalid;
            r_ofound <= n_ofound;
            r_ocx    <= n_ocx;
            r_ocy    <= n_ocy;
        end
    end

    assign o_stall      = (r_state != S_LOAD);
    assign o_valid      = r_ovalid;
    assign o_found      = r_ofound;
    assign o_centroid_x = r_ocx;
    assign o_centroid_y = r_ocy;

endmodule

/* rtl/rpwc_div.sv */
// Restoring divider, one quotient bit per cycle.
module rpwc_div #(
    parameter int N_W = 38,
    parameter int D_W = 19
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);

    localparam int CW = (N_W > 1) ? $clog2(N_W) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(N_W - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N_W-1:0] r_num;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;

    logic [D_W:0]   w_trial;
    logic           w_fit;
    logic [D_W-1:0] w_rem;

    // Shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_num[N_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_rem   = w_fit ? D_W'(w_trial - {1'b0, r_den}) : w_trial[D_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // Load operands
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                // Advance one bit; quotient bits fill the vacated dividend bits
                r_rem <= w_rem;
                r_num <= {r_num[N_W-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

/* rtl/rpwc_chk.sv */
`include "ray_peak_window_centroid_core_defines.svh"

// Port-level checks of the result channel.
module rpwc_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_found,
    input logic [rpwc_pkg::OUT_W-1:0] o_centroid_x,
    input logic [rpwc_pkg::OUT_W-1:0] o_centroid_y
);

    // Hold a stalled result
    `RPWC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // Keep a stalled payload steady
    `RPWC_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_found) && $stable(o_centroid_x) && $stable(o_centroid_y))

    // A miss carries zero centroids
    `RPWC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found, o_centroid_x == '0 && o_centroid_y == '0)

    // A new result only follows evaluation, while input is stalled
    `RPWC_ASSERT_IMP(a_rise_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

endmodule

bind ray_peak_window_centroid_core rpwc_chk u_rpwc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_found      (o_found),
    .o_centroid_x (o_centroid_x),
    .o_centroid_y (o_centroid_y)
);
